// ===== src/cdq_pkg.sv =====
// Shared constants, codes and types of the circular deque.
package cdq_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CAP_W = PTR_W + 1;
	localparam int FUNC_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_REAR = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_PEEK = 3'd4;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_FULL = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic read;
	} cmd_t;

endpackage

// ===== src/cdq_ctrl.sv =====
// Controller state machine sequencing load, execute, read and response.
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_READ;
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				state_d = accept ? ST_EXEC : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		done = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EXEC: begin
				busy = 1'b1;
				cmd.exec = 1'b1;
			end
			ST_READ: begin
				busy = 1'b1;
				cmd.read = 1'b1;
			end
			ST_RESP: begin
				done = 1'b1;
				cmd.load = start;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/cdq_datapath.sv =====
// Datapath: ring store, head and tail pointers, capacity and result registers.
module cdq_datapath
	import cdq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic                cfg_wr_en,
	input  logic [CAP_W-1:0]    cfg_wr_data,
	input  logic [FUNC_W-1:0]   func,
	input  logic signed [DATA_W-1:0] push_value,
	output logic [1:0]          status,
	output logic signed [DATA_W-1:0] popped_value,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value,
	output logic [PTR_W-1:0]    front_slot,
	output logic [PTR_W-1:0]    rear_slot,
	output logic                is_empty
);

	logic [DATA_W-1:0] ring_q [DEPTH];

	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic              empty_q;
	logic [PTR_W-1:0]  cap_m1_q;
	logic [PTR_W-1:0]  cap_m1_d;

	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] push_q;
	status_t           status_q;
	logic [DATA_W-1:0] popped_q;
	logic [DATA_W-1:0] front_q;
	logic [DATA_W-1:0] rear_q;

	logic [PTR_W-1:0]  head_d;
	logic [PTR_W-1:0]  tail_d;
	logic              empty_d;
	status_t           status_d;
	logic [DATA_W-1:0] popped_d;
	logic              wr_en_d;
	logic [PTR_W-1:0]  wr_addr_d;
	logic              full;
	logic              is_push;
	logic              is_pop;

	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_m1_d = '0;
		end else if (cfg_wr_data > CAP_W'(DEPTH)) begin
			cap_m1_d = PTR_W'(DEPTH - 1);
		end else begin
			cap_m1_d = PTR_W'(cfg_wr_data - CAP_W'(1));
		end
	end

	assign full = !empty_q && (((head_q == '0) && (tail_q == cap_m1_q)) ||
		((head_q != '0) && (tail_q == head_q - PTR_W'(1))));
	assign is_push = (func_q == FUNC_PUSH_FRONT) || (func_q == FUNC_PUSH_REAR);
	assign is_pop = (func_q == FUNC_POP_FRONT) || (func_q == FUNC_POP_REAR);

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		empty_d = empty_q;
		status_d = STAT_DONE;
		popped_d = '0;
		wr_en_d = 1'b0;
		wr_addr_d = '0;
		priority if (is_push) begin
			priority if (empty_q) begin
				head_d = '0;
				tail_d = '0;
				empty_d = 1'b0;
				wr_en_d = 1'b1;
			end else if (full) begin
				status_d = STAT_FULL;
			end else if (func_q == FUNC_PUSH_FRONT) begin
				head_d = (head_q == '0) ? cap_m1_q : head_q - PTR_W'(1);
				wr_en_d = 1'b1;
				wr_addr_d = head_d;
			end else begin
				tail_d = (tail_q >= cap_m1_q) ? '0 : tail_q + PTR_W'(1);
				wr_en_d = 1'b1;
				wr_addr_d = tail_d;
			end
		end else if (is_pop) begin
			priority if (empty_q) begin
				status_d = STAT_EMPTY;
			end else begin
				popped_d = (func_q == FUNC_POP_FRONT) ? front_q : rear_q;
				priority if (head_q == tail_q) begin
					head_d = '0;
					tail_d = '0;
					empty_d = 1'b1;
				end else if (func_q == FUNC_POP_FRONT) begin
					head_d = (head_q >= cap_m1_q) ? '0 : head_q + PTR_W'(1);
				end else begin
					tail_d = (tail_q == '0) ? cap_m1_q : tail_q - PTR_W'(1);
				end
			end
		end else begin
			if (empty_q) status_d = STAT_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
			cap_m1_q <= PTR_W'(DEPTH - 1);
		end else if (cfg_wr_en) begin
			cap_m1_q <= cap_m1_d;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			push_q <= push_value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			popped_q <= popped_d;
			if (wr_en_d) ring_q[wr_addr_d] <= push_q;
		end
		if (cmd.read) begin
			front_q <= ring_q[head_q];
			rear_q <= ring_q[tail_q];
		end
	end

	assign status = status_q;
	assign popped_value = popped_q;
	assign front_value = empty_q ? '0 : front_q;
	assign rear_value = empty_q ? '0 : rear_q;
	assign front_slot = empty_q ? '0 : head_q;
	assign rear_slot = empty_q ? '0 : tail_q;
	assign is_empty = empty_q;

endmodule

// ===== src/circular_deque.sv =====
// Top level of the circular deque: controller and datapath.
// After the accepting edge the controller steps through EXEC and READ to RESP, where done is high.
// The next start is taken while done is high; the deque is busy in EXEC and READ.
// Execute, ring-store read and response are successive states of the sequencer.
// Reset: pointers zero, queue empty, capacity 16; ring contents are not cleared.
// The receiver cannot stall: each result is shown for one cycle with done.
module circular_deque
	import cdq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	output logic                     done,
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         cfg_wr_data,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] push_value,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] popped_value,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value,
	output logic [PTR_W-1:0]         front_slot,
	output logic [PTR_W-1:0]         rear_slot,
	output logic                     is_empty
);

	cmd_t cmd;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cdq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.func         (func),
		.push_value   (push_value),
		.status       (status),
		.popped_value (popped_value),
		.front_value  (front_value),
		.rear_value   (rear_value),
		.front_slot   (front_slot),
		.rear_slot    (rear_slot),
		.is_empty     (is_empty)
	);

endmodule

// ===== tb/circular_deque_test.sv =====
// Self-checking testbench of the circular deque: directed table, then random phases.
module circular_deque_test;
	import cdq_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_C = 3'd7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 56;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		status_t                  st;
		logic signed [DATA_W-1:0] popped;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] rear;
		logic [PTR_W-1:0]         front_idx;
		logic [PTR_W-1:0]         rear_idx;
		logic                     empty;
	} deque_view_t;

	typedef struct {
		bit                is_cfg;
		logic [CAP_W-1:0]  capacity;
		logic [FUNC_W-1:0] op;
		logic [DATA_W-1:0] value;
		bit                typed;
		deque_view_t       want;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     done;
	logic                     cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]         cfg_wr_data = '0;
	logic [FUNC_W-1:0]        func = '0;
	logic signed [DATA_W-1:0] push_value = '0;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] popped_value;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] rear_value;
	logic [PTR_W-1:0]         front_slot;
	logic [PTR_W-1:0]         rear_slot;
	logic                     is_empty;

	logic signed [DATA_W-1:0] ring_copy [DEPTH];
	logic [PTR_W-1:0]         head_copy = '0;
	logic [PTR_W-1:0]         tail_copy = '0;
	logic                     empty_copy = 1'b1;
	logic [CAP_W-1:0]         capacity_copy = CAP_W'(DEPTH);

	deque_view_t expected_views [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          sender_idle_pct = 0;

	circular_deque dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.func        (func),
		.push_value  (push_value),
		.status      (status),
		.popped_value(popped_value),
		.front_value (front_value),
		.rear_value  (rear_value),
		.front_slot  (front_slot),
		.rear_slot   (rear_slot),
		.is_empty    (is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("circular_deque: mismatch");
			$finish;
		end
	end

	function automatic deque_view_t view(input status_t st, input logic [DATA_W-1:0] popped,
			input logic [DATA_W-1:0] front, input logic [DATA_W-1:0] rear,
			input logic [PTR_W-1:0] front_idx, input logic [PTR_W-1:0] rear_idx,
			input logic empty);
		deque_view_t v;
		v.st = st;
		v.popped = popped;
		v.front = front;
		v.rear = rear;
		v.front_idx = front_idx;
		v.rear_idx = rear_idx;
		v.empty = empty;
		return v;
	endfunction

	function automatic stim_row_t req_row(input logic [FUNC_W-1:0] op,
			input logic [DATA_W-1:0] value);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.capacity = '0;
		r.op = op;
		r.value = value;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t known_row(input logic [FUNC_W-1:0] op,
			input logic [DATA_W-1:0] value, input deque_view_t want);
		stim_row_t r;
		r = req_row(op, value);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t cap_row(input logic [CAP_W-1:0] capacity);
		stim_row_t r;
		r = req_row(FUNC_PEEK, '0);
		r.is_cfg = 1'b1;
		r.capacity = capacity;
		return r;
	endfunction

	// Advance the local copy of the deque by one request and return what it should report.
	function automatic deque_view_t predict_request(input logic [FUNC_W-1:0] op,
			input logic signed [DATA_W-1:0] value);
		int          cap;
		bit          full;
		deque_view_t r;
		cap = (capacity_copy == 0) ? 1 : (int'(capacity_copy) > DEPTH) ? DEPTH
			: int'(capacity_copy);
		full = !empty_copy && ((head_copy == 0 && int'(tail_copy) == cap - 1) ||
			(head_copy != 0 && tail_copy == head_copy - 1'b1));
		r = '0;
		r.st = STAT_DONE;
		case (op)
			FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
				if (empty_copy) begin
					head_copy = '0;
					tail_copy = '0;
					empty_copy = 1'b0;
					ring_copy[0] = value;
				end else if (full) begin
					r.st = STAT_FULL;
				end else if (op == FUNC_PUSH_FRONT) begin
					head_copy = (head_copy == 0) ? PTR_W'(cap - 1) : head_copy - 1'b1;
					ring_copy[head_copy] = value;
				end else begin
					tail_copy = (int'(tail_copy) >= cap - 1) ? '0 : tail_copy + 1'b1;
					ring_copy[tail_copy] = value;
				end
			end
			FUNC_POP_FRONT, FUNC_POP_REAR: begin
				if (empty_copy) begin
					r.st = STAT_EMPTY;
				end else begin
					r.popped = (op == FUNC_POP_FRONT) ? ring_copy[head_copy]
						: ring_copy[tail_copy];
					if (head_copy == tail_copy) begin
						head_copy = '0;
						tail_copy = '0;
						empty_copy = 1'b1;
					end else if (op == FUNC_POP_FRONT) begin
						head_copy = (int'(head_copy) >= cap - 1) ? '0 : head_copy + 1'b1;
					end else begin
						tail_copy = (tail_copy == 0) ? PTR_W'(cap - 1) : tail_copy - 1'b1;
					end
				end
			end
			default: begin
				if (empty_copy)
					r.st = STAT_EMPTY;
			end
		endcase
		if (empty_copy) begin
			r.empty = 1'b1;
		end else begin
			r.front = ring_copy[head_copy];
			r.rear = ring_copy[tail_copy];
			r.front_idx = head_copy;
			r.rear_idx = tail_copy;
		end
		return r;
	endfunction

	task automatic issue(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] value,
			input bit typed, input deque_view_t want);
		deque_view_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		push_value <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = predict_request(op, value);
		expected_views.push_back(typed ? want : predicted);
	endtask

	// Hold requests off until the deque is idle, then write the capacity.
	task automatic write_capacity(input logic [CAP_W-1:0] capacity);
		start <= 1'b0;
		@(posedge clk);
		while (expected_views.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= capacity;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity_copy = capacity;
		head_copy = '0;
		tail_copy = '0;
		empty_copy = 1'b1;
	endtask

	always @(posedge clk) begin
		deque_view_t got;
		deque_view_t want;
		if (arst_n && done) begin
			got.st = status_t'(status);
			got.popped = popped_value;
			got.front = front_value;
			got.rear = rear_value;
			got.front_idx = front_slot;
			got.rear_idx = rear_slot;
			got.empty = is_empty;
			if (expected_views.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: st=%0d pop=%h front=%h rear=%h fi=%0d ri=%0d e=%b",
						got.st, got.popped, got.front, got.rear, got.front_idx,
						got.rear_idx, got.empty);
			end else begin
				want = expected_views.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("expected st=%0d pop=%h front=%h rear=%h fi=%0d ri=%0d e=%b",
							want.st, want.popped, want.front, want.rear, want.front_idx,
							want.rear_idx, want.empty);
						$display("actual   st=%0d pop=%h front=%h rear=%h fi=%0d ri=%0d e=%b",
							got.st, got.popped, got.front, got.rear, got.front_idx,
							got.rear_idx, got.empty);
					end
				end
			end
		end
	end

	initial begin
		stim_row_t   directed [$];
		stim_row_t   row;
		int          phase_cap [PHASES];
		int          phase_idle [PHASES];
		int          seg_left;
		int          push_bias;
		int          pick;
		logic [FUNC_W-1:0] op;
		logic [DATA_W-1:0] value;
		deque_view_t none;

		none = '0;
		phase_cap = '{16, 1, 5, 0, 31, 2, 0, 0};
		phase_idle = '{0, 62, 31, 0, 62, 31, 62, 0};
		phase_cap[6] = $urandom_range(1, DEPTH);
		phase_cap[7] = $urandom_range(0, 31);

		directed = {
			known_row(FUNC_PEEK, 32'h0, view(STAT_EMPTY, 0, 0, 0, 0, 0, 1'b1)),
			known_row(FUNC_POP_FRONT, 32'h0, view(STAT_EMPTY, 0, 0, 0, 0, 0, 1'b1)),
			known_row(FUNC_POP_REAR, 32'h1234, view(STAT_EMPTY, 0, 0, 0, 0, 0, 1'b1)),
			known_row(FUNC_PUSH_REAR, 32'h7FFFFFFF,
				view(STAT_DONE, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1'b0)),
			known_row(FUNC_PUSH_FRONT, 32'h80000000,
				view(STAT_DONE, 0, 32'h80000000, 32'h7FFFFFFF, 15, 0, 1'b0)),
			req_row(FUNC_PUSH_REAR, 32'hFFFFFFFF),
			req_row(FUNC_RSVD_A, 32'h0),
			req_row(FUNC_RSVD_B, 32'hFFFFFFFF),
			req_row(FUNC_RSVD_C, 32'h0),
			known_row(FUNC_POP_FRONT, 32'h0,
				view(STAT_DONE, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 1, 1'b0)),
			req_row(FUNC_POP_REAR, 32'h0),
			known_row(FUNC_POP_REAR, 32'h0, view(STAT_DONE, 32'h7FFFFFFF, 0, 0, 0, 0, 1'b1)),
			req_row(FUNC_POP_FRONT, 32'h0),
			cap_row(5'd0),
			known_row(FUNC_PUSH_FRONT, 32'h55555555,
				view(STAT_DONE, 0, 32'h55555555, 32'h55555555, 0, 0, 1'b0)),
			known_row(FUNC_PUSH_REAR, 32'hAAAAAAAA,
				view(STAT_FULL, 0, 32'h55555555, 32'h55555555, 0, 0, 1'b0)),
			req_row(FUNC_PUSH_FRONT, 32'h0),
			req_row(FUNC_POP_FRONT, 32'h0),
			req_row(FUNC_PUSH_REAR, 32'hAAAAAAAA),
			cap_row(5'd31),
			known_row(FUNC_PEEK, 32'h0, view(STAT_EMPTY, 0, 0, 0, 0, 0, 1'b1)),
			cap_row(5'd2),
			req_row(FUNC_PUSH_FRONT, 32'h1),
			req_row(FUNC_PUSH_FRONT, 32'h2),
			req_row(FUNC_PUSH_REAR, 32'h3),
			req_row(FUNC_POP_REAR, 32'h0),
			req_row(FUNC_PUSH_REAR, 32'h4),
			req_row(FUNC_PUSH_FRONT, 32'h5),
			cap_row(5'd16)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			if (row.is_cfg)
				write_capacity(row.capacity);
			else
				issue(row.op, row.value, row.typed, row.want);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(CAP_W'(phase_cap[p]));
			sender_idle_pct = phase_idle[p];
			seg_left = 0;
			push_bias = 75;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 40);
					push_bias = (push_bias == 75) ? 25 : 75;
				end
				seg_left--;
				pick = $urandom_range(99);
				if (pick < 4)
					op = FUNC_RSVD_A + FUNC_W'($urandom_range(2));
				else if (pick < 12)
					op = FUNC_PEEK;
				else if ($urandom_range(99) < push_bias)
					op = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
				else
					op = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_REAR;
				if ($urandom_range(7) == 0) begin
					case ($urandom_range(3))
						0: value = 32'h0;
						1: value = 32'hFFFFFFFF;
						2: value = 32'h7FFFFFFF;
						default: value = 32'h80000000;
					endcase
				end else begin
					value = $urandom;
				end
				issue(op, value, 1'b0, none);
			end
		end

		start <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_views.size() == 0)
			$display("circular_deque: match");
		else
			$display("circular_deque: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cdq_pkg.sv
src/cdq_ctrl.sv
src/cdq_datapath.sv
src/circular_deque.sv
tb/circular_deque_test.sv
